FILE: rtl/srec_record_encoder_defines.svh
// ---------------------------------------------------------------------------
// S-record encoder assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SREC_RECORD_ENCODER_DEFINES_SVH
`define SREC_RECORD_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SREC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SREC_ASSERT_IMP(lbl, ante, cons, msg)
`define SREC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/srec_pkg.sv
// ---------------------------------------------------------------------------
// S-record encoder package
// Request kinds, controller states, command and status bundles, ASCII tables.
// ---------------------------------------------------------------------------
package srec_pkg;

  localparam int CFG_W  = 5;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 24;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd24;

  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_2   = 8'h32;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // byte count overhead: address bytes plus checksum
  localparam logic [7:0] S1_OVERHEAD = 8'd3;
  localparam logic [7:0] S2_OVERHEAD = 8'd4;

  // step counter marks
  localparam logic [CNT_W-1:0] CNT_ADDR_WIDE   = 4'd0;
  localparam logic [CNT_W-1:0] CNT_ADDR_NARROW = 4'd2;
  localparam logic [CNT_W-1:0] CNT_ADDR_LAST   = 4'd5;
  localparam logic [CNT_W-1:0] CNT_NUL_LAST    = 4'd1;
  localparam logic [CNT_W-1:0] CNT_END_LAST    = 4'd10;

  typedef enum logic [1:0] {
    KIND_SET_ADDR = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_TERM     = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S,
    ST_TYPE,
    ST_CNT_HI,
    ST_CNT_LO,
    ST_ADDR,
    ST_DATA_HI,
    ST_DATA_LO,
    ST_SUM_HI,
    ST_SUM_LO,
    ST_NL,
    ST_NUL,
    ST_END
  } state_t;

  typedef enum logic [3:0] {
    SEL_S,
    SEL_TYPE,
    SEL_CNT_HI,
    SEL_CNT_LO,
    SEL_ADDR,
    SEL_DATA_HI,
    SEL_DATA_LO,
    SEL_SUM_HI,
    SEL_SUM_LO,
    SEL_NL,
    SEL_NUL,
    SEL_END
  } sel_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic last;
    sel_t sel;
    logic fetch;
    logic cnt_clr;
    logic cnt_addr;
    logic cnt_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rec_due;
    logic out_free;
    logic addr_done;
    logic byte_done;
    logic nul_done;
    logic end_done;
  } dp_stat_t;

  // upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide_nib;
    wide_nib = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide_nib;
    end
    return 8'h37 + wide_nib;
  endfunction

  // fixed end line "S9030000FC\n"
  function automatic logic [7:0] end_char(input logic [CNT_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h53;
      4'd1:    ch = 8'h39;
      4'd2:    ch = 8'h30;
      4'd3:    ch = 8'h33;
      4'd4:    ch = 8'h30;
      4'd5:    ch = 8'h30;
      4'd6:    ch = 8'h30;
      4'd7:    ch = 8'h30;
      4'd8:    ch = 8'h46;
      4'd9:    ch = 8'h43;
      4'd10:   ch = 8'h0A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/srec_record_encoder.sv
// A request that closes a record goes through the state register and then the
//   output register; an S1 record of n bytes is 13 + 2*n characters, S2 is 15 + 2*n and
//   the end line is 11, at one per cycle while the output is not stalled. The input is
//   held while text goes out; a data byte that only fills the buffer leaves in_ready high.
// Reset: rst_n is synchronous, active low; it empties the buffer, zeroes the
//   addresses and sets the record length to 24.
// ---------------------------------------------------------------------------
// S-record encoder top level
// Turns load requests into S1/S2 record text with a fixed S9 end line.
// ---------------------------------------------------------------------------
module srec_record_encoder #(
  parameter int MAX_RECORD_BYTES = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [srec_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_data_byte,
  input  logic [srec_pkg::ADDR_W-1:0] in_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        out_last,
  output logic                        out_dropped
);

  srec_pkg::ctrl_cmd_t cmd;
  srec_pkg::dp_stat_t  stat;

  // sequencer
  srec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  // record storage and character generation
  srec_dp #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .in_address   (in_address),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_dropped  (out_dropped)
  );

endmodule

FILE: rtl/srec_ctrl.sv
// ---------------------------------------------------------------------------
// S-record encoder controller
// Sequences the characters of one record or of the end line.
// ---------------------------------------------------------------------------
`include "srec_record_encoder_defines.svh"

module srec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  srec_pkg::dp_stat_t  stat,
  output srec_pkg::ctrl_cmd_t cmd
);

  srec_pkg::state_t state_r;
  srec_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = srec_pkg::SEL_S;
    in_ready  = 1'b0;
    unique case (state_r)
      srec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (srec_pkg::kind_t'(in_kind) == srec_pkg::KIND_TERM) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = srec_pkg::ST_END;
          end else if (stat.rec_due) begin
            state_nxt = srec_pkg::ST_S;
          end
        end
      end
      srec_pkg::ST_S: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_S;
          state_nxt = srec_pkg::ST_TYPE;
        end
      end
      srec_pkg::ST_TYPE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_TYPE;
          state_nxt = srec_pkg::ST_CNT_HI;
        end
      end
      srec_pkg::ST_CNT_HI: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_CNT_HI;
          state_nxt = srec_pkg::ST_CNT_LO;
        end
      end
      srec_pkg::ST_CNT_LO: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sel      = srec_pkg::SEL_CNT_LO;
          cmd.cnt_addr = 1'b1;
          state_nxt    = srec_pkg::ST_ADDR;
        end
      end
      srec_pkg::ST_ADDR: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = srec_pkg::SEL_ADDR;
          cmd.cnt_inc = 1'b1;
          // a record always holds at least one byte: prefetch the first
          if (stat.addr_done) begin
            cmd.fetch = 1'b1;
            state_nxt = srec_pkg::ST_DATA_HI;
          end
        end
      end
      srec_pkg::ST_DATA_HI: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_DATA_HI;
          state_nxt = srec_pkg::ST_DATA_LO;
        end
      end
      srec_pkg::ST_DATA_LO: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = srec_pkg::SEL_DATA_LO;
          if (stat.byte_done) begin
            state_nxt = srec_pkg::ST_SUM_HI;
          end else begin
            cmd.fetch = 1'b1;
            state_nxt = srec_pkg::ST_DATA_HI;
          end
        end
      end
      srec_pkg::ST_SUM_HI: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_SUM_HI;
          state_nxt = srec_pkg::ST_SUM_LO;
        end
      end
      srec_pkg::ST_SUM_LO: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = srec_pkg::SEL_SUM_LO;
          state_nxt = srec_pkg::ST_NL;
        end
      end
      srec_pkg::ST_NL: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = srec_pkg::SEL_NL;
          cmd.cnt_clr = 1'b1;
          state_nxt   = srec_pkg::ST_NUL;
        end
      end
      srec_pkg::ST_NUL: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = srec_pkg::SEL_NUL;
          cmd.cnt_inc = 1'b1;
          if (stat.nul_done) begin
            cmd.last  = 1'b1;
            state_nxt = srec_pkg::ST_IDLE;
          end
        end
      end
      srec_pkg::ST_END: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = srec_pkg::SEL_END;
          cmd.cnt_inc = 1'b1;
          if (stat.end_done) begin
            cmd.last  = 1'b1;
            state_nxt = srec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = srec_pkg::ST_IDLE;
      end
    endcase
  end

  `SREC_ASSERT_IMP(a_emit_room, cmd.emit, stat.out_free, "character issued into a full output")
  `SREC_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state_r == srec_pkg::ST_IDLE, "not idle after last")
  `SREC_ASSERT_NEXT(a_term_end, cmd.accept && (in_kind == srec_pkg::KIND_TERM), state_r == srec_pkg::ST_END, "terminate did not start end line")

endmodule

FILE: rtl/srec_dp.sv
// ---------------------------------------------------------------------------
// S-record encoder datapath
// Byte store, record bookkeeping, checksum, character mux and output register.
// ---------------------------------------------------------------------------
`include "srec_record_encoder_defines.svh"

module srec_dp #(
  parameter int MAX_RECORD_BYTES = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [srec_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic [1:0]                       in_kind,
  input  logic [7:0]                       in_data_byte,
  input  logic [srec_pkg::ADDR_W-1:0]      in_address,
  input  srec_pkg::ctrl_cmd_t              cmd,
  output srec_pkg::dp_stat_t               stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [7:0]                       out_char,
  output logic                             out_last,
  output logic                             out_dropped
);

  localparam int FILL_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int IDX_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int LEN_W  = srec_pkg::CFG_W + 1;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_RECORD_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_RECORD_BYTES);

  localparam int AW = srec_pkg::ADDR_W;

  logic [7:0] store_mem [MAX_RECORD_BYTES];

  logic [srec_pkg::CFG_W-1:0] cfg_r;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [AW-1:0]              rec_start_r, rec_start_nxt;
  logic [AW-1:0]              next_addr_r, next_addr_nxt;
  logic                       drop_r, drop_nxt;

  logic [AW-1:0]              em_start_r, em_start_nxt;
  logic [FILL_W-1:0]          em_fill_r, em_fill_nxt;
  logic [7:0]                 em_sum_r, em_sum_nxt;
  logic [7:0]                 chk_r;

  logic [FILL_W-1:0]          rd_idx_r;
  logic [7:0]                 rd_data_r;
  logic [srec_pkg::CNT_W-1:0] cnt_r;

  logic                       out_valid_r;
  logic [7:0]                 out_char_r;
  logic                       out_last_r;
  logic                       out_dropped_r;

  srec_pkg::kind_t            kind;
  logic [FILL_W-1:0]          fill_inc;
  logic [7:0]                 sum_inc;
  logic [AW-1:0]              start_data;
  logic [LEN_W-1:0]           len_eff;
  logic                       full_due;
  logic                       rec_due;
  logic                       wide;
  logic [7:0]                 cnt_byte;
  logic [3:0]                 addr_nib;
  logic [7:0]                 char_sel;

  assign kind       = srec_pkg::kind_t'(in_kind);
  assign fill_inc   = fill_r + FILL_W'(1);
  assign sum_inc    = sum_r + in_data_byte;
  assign start_data = (fill_r == '0) ? next_addr_r : rec_start_r;

  // clamp record length into 1..MAX_RECORD_BYTES
  always_comb begin
    if (cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(cfg_r) > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = LEN_W'(cfg_r);
    end
  end

  assign full_due = LEN_W'(fill_inc) >= len_eff;

  // record due on this request
  always_comb begin
    case (kind)
      srec_pkg::KIND_DATA: rec_due = full_due;
      srec_pkg::KIND_TERM: rec_due = 1'b0;
      default:             rec_due = (fill_r != '0);
    endcase
  end

  // bookkeeping update and record snapshot at accept
  always_comb begin
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    rec_start_nxt = rec_start_r;
    next_addr_nxt = next_addr_r;
    drop_nxt      = drop_r;
    em_start_nxt  = em_start_r;
    em_fill_nxt   = em_fill_r;
    em_sum_nxt    = em_sum_r;
    if (cmd.accept) begin
      case (kind)
        srec_pkg::KIND_SET_ADDR: begin
          em_start_nxt  = rec_start_r;
          em_fill_nxt   = fill_r;
          em_sum_nxt    = sum_r;
          fill_nxt      = '0;
          sum_nxt       = '0;
          rec_start_nxt = in_address;
          next_addr_nxt = in_address;
        end
        srec_pkg::KIND_DATA: begin
          em_start_nxt  = start_data;
          em_fill_nxt   = fill_inc;
          em_sum_nxt    = sum_inc;
          rec_start_nxt = start_data;
          next_addr_nxt = next_addr_r + AW'(1);
          fill_nxt      = full_due ? '0 : fill_inc;
          sum_nxt       = full_due ? '0 : sum_inc;
        end
        srec_pkg::KIND_FLUSH: begin
          em_start_nxt = rec_start_r;
          em_fill_nxt  = fill_r;
          em_sum_nxt   = sum_r;
          fill_nxt     = '0;
          sum_nxt      = '0;
        end
        default: begin
          drop_nxt = (fill_r != '0);
          fill_nxt = '0;
          sum_nxt  = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= srec_pkg::CFG_RESET;
      fill_r      <= '0;
      sum_r       <= '0;
      rec_start_r <= '0;
      next_addr_r <= '0;
      drop_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      rec_start_r <= rec_start_nxt;
      next_addr_r <= next_addr_nxt;
      drop_r      <= drop_nxt;
    end
  end

  // record snapshot and checksum
  assign wide     = |em_start_r[AW-1:16];
  assign cnt_byte = 8'(em_fill_r) + (wide ? srec_pkg::S2_OVERHEAD : srec_pkg::S1_OVERHEAD);

  always_ff @(posedge clk) begin
    em_start_r <= em_start_nxt;
    em_fill_r  <= em_fill_nxt;
    em_sum_r   <= em_sum_nxt;
    chk_r      <= ~(em_sum_r + cnt_byte + em_start_r[23:16] + em_start_r[15:8]
                    + em_start_r[7:0]);
  end

  // byte store: write on data request, registered read on fetch
  always_ff @(posedge clk) begin
    if (cmd.accept && (kind == srec_pkg::KIND_DATA)) begin
      store_mem[fill_r[IDX_W-1:0]] <= in_data_byte;
    end
    if (cmd.fetch) begin
      rd_data_r <= store_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  // read index and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.accept) begin
        rd_idx_r <= '0;
      end else if (cmd.fetch) begin
        rd_idx_r <= rd_idx_r + FILL_W'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_addr) begin
        cnt_r <= wide ? srec_pkg::CNT_ADDR_WIDE : srec_pkg::CNT_ADDR_NARROW;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + srec_pkg::CNT_W'(1);
      end
    end
  end

  // address nibble, most significant first
  always_comb begin
    case (cnt_r)
      4'd0:    addr_nib = em_start_r[23:20];
      4'd1:    addr_nib = em_start_r[19:16];
      4'd2:    addr_nib = em_start_r[15:12];
      4'd3:    addr_nib = em_start_r[11:8];
      4'd4:    addr_nib = em_start_r[7:4];
      default: addr_nib = em_start_r[3:0];
    endcase
  end

  // character mux
  always_comb begin
    unique case (cmd.sel)
      srec_pkg::SEL_S:       char_sel = srec_pkg::CH_S;
      srec_pkg::SEL_TYPE:    char_sel = wide ? srec_pkg::CH_2 : srec_pkg::CH_1;
      srec_pkg::SEL_CNT_HI:  char_sel = srec_pkg::hex_char(cnt_byte[7:4]);
      srec_pkg::SEL_CNT_LO:  char_sel = srec_pkg::hex_char(cnt_byte[3:0]);
      srec_pkg::SEL_ADDR:    char_sel = srec_pkg::hex_char(addr_nib);
      srec_pkg::SEL_DATA_HI: char_sel = srec_pkg::hex_char(rd_data_r[7:4]);
      srec_pkg::SEL_DATA_LO: char_sel = srec_pkg::hex_char(rd_data_r[3:0]);
      srec_pkg::SEL_SUM_HI:  char_sel = srec_pkg::hex_char(chk_r[7:4]);
      srec_pkg::SEL_SUM_LO:  char_sel = srec_pkg::hex_char(chk_r[3:0]);
      srec_pkg::SEL_NL:      char_sel = srec_pkg::CH_NL;
      srec_pkg::SEL_NUL:     char_sel = srec_pkg::CH_NUL;
      srec_pkg::SEL_END:     char_sel = srec_pkg::end_char(cnt_r);
      default:               char_sel = srec_pkg::CH_NUL;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r    <= char_sel;
      out_last_r    <= cmd.last;
      out_dropped_r <= (cmd.sel == srec_pkg::SEL_END) && drop_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_dropped_r;

  // status toward the controller
  always_comb begin
    stat           = '0;
    stat.rec_due   = rec_due;
    stat.out_free  = !out_valid_r || out_ready;
    stat.addr_done = (cnt_r == srec_pkg::CNT_ADDR_LAST);
    stat.byte_done = (rd_idx_r == em_fill_r);
    stat.nul_done  = (cnt_r == srec_pkg::CNT_NUL_LAST);
    stat.end_done  = (cnt_r == srec_pkg::CNT_END_LAST);
  end

  `SREC_ASSERT_IMP(a_fill_bound, 1'b1, fill_r < FILL_MAX, "byte store over full")
  `SREC_ASSERT_IMP(a_fetch_range, cmd.fetch, rd_idx_r < em_fill_r, "fetch past record end")
  `SREC_ASSERT_NEXT(a_rec_nonempty, cmd.accept && rec_due, em_fill_r != '0, "empty record started")

endmodule
